// ===== hdl/lvs_pkg.sv =====
// lvs_pkg: sizes, row type, command codes and helpers for the lru victim select unit
// shared by the victim picker and the top level; no dependencies

package lvs_pkg;

  // geometry
  localparam int NUM_SETS  = 64;
  localparam int NUM_WAYS  = 4;
  localparam int TIME_BITS = 32;

  // widths of the input and output fields
  localparam int CMD_W    = 2;
  localparam int SET_W    = 6;
  localparam int WAYF_W   = 2;
  localparam int NOW_W    = 32;
  localparam int MASK_W   = 4;
  localparam int VWAY_W   = 2;
  localparam int IN_BITS  = CMD_W + SET_W + WAYF_W + NOW_W + MASK_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 1 + VWAY_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // internal index widths
  localparam int ADDR_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INVAL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // one memory row holds the time stamps of every way of a set
  typedef logic [NUM_WAYS-1:0][TIME_BITS-1:0] row_t;

  // result of a victim search
  typedef struct packed {
    logic             found;
    logic [WAY_W-1:0] way;
  } victim_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // set number to memory row address
  function automatic logic [ADDR_W-1:0] set_addr(input logic [SET_W-1:0] set);
    logic [ADDR_W+SET_W-1:0] ext;
    ext = {{ADDR_W{1'b0}}, set};
    return ext[ADDR_W-1:0];
  endfunction

  // set number lies inside the cache
  function automatic logic set_ok(input logic [SET_W-1:0] set);
    logic [ADDR_W+SET_W:0] ext;
    ext = {{(ADDR_W+1){1'b0}}, set};
    return (ext < NUM_SETS);
  endfunction

  // way number lies inside the set
  function automatic logic way_ok(input logic [WAYF_W-1:0] way);
    logic [WAY_W+WAYF_W:0] ext;
    ext = {{(WAY_W+1){1'b0}}, way};
    return (ext < NUM_WAYS);
  endfunction

  // way number to row slot
  function automatic logic [WAY_W-1:0] way_slot(input logic [WAYF_W-1:0] way);
    logic [WAY_W+WAYF_W-1:0] ext;
    ext = {{WAY_W{1'b0}}, way};
    return ext[WAY_W-1:0];
  endfunction

  // incoming time kept in its low TIME_BITS bits
  function automatic logic [TIME_BITS-1:0] fit_time(input logic [NOW_W-1:0] now);
    logic [TIME_BITS+NOW_W-1:0] ext;
    ext = {{TIME_BITS{1'b0}}, now};
    return ext[TIME_BITS-1:0];
  endfunction

endpackage

// ===== hdl/lru_victim_select_with_disabled_ways_unit.sv =====
// lru_victim_select_with_disabled_ways_unit: timestamp lru replacement engine
// depends on lvs_pkg, lvs_time_ram and lvs_victim_pick
//
//  channel  dir  width  word
//  s_axis   in   48     command, set, way, time stamp, disabled mask
//  m_axis   out  8      victim flag and victim way (victim queries only)
//
// each word is accepted with its row read, then modified and written back
// or searched for a victim; no new word is accepted until the last is done.
// a query whose result cannot leave holds in the execute state until m_axis
// takes the waiting result; invalidate and touch never wait.
// reset clears a valid bit per set at once, so every time stamp reads as zero.

module lru_victim_select_with_disabled_ways_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // cmd[1:0], set_index[7:2], way_index[9:8], now_time[41:10], disabled_mask[45:42]
  input  logic [lvs_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // victim_found[0], victim_way[2:1]
  output logic [lvs_pkg::OUT_W-1:0] m_axis_tdata
);
  import lvs_pkg::*;

  // field positions in the input word
  localparam int CMD_LSB  = 0;
  localparam int SET_LSB  = CMD_LSB + CMD_W;
  localparam int WAY_LSB  = SET_LSB + SET_W;
  localparam int NOW_LSB  = WAY_LSB + WAYF_W;
  localparam int MASK_LSB = NOW_LSB + NOW_W;

  state_e state_q, state_d;

  logic [CMD_W-1:0]    cmd_q;
  logic [SET_W-1:0]    set_q;
  logic [WAYF_W-1:0]   way_q;
  logic [NOW_W-1:0]    now_q;
  logic [MASK_W-1:0]   mask_q;
  logic                rvld_q;
  logic [NUM_SETS-1:0] valid_q;
  logic                out_valid_q, out_valid_d;
  logic                out_found_q;
  logic [VWAY_W-1:0]   out_way_q;

  logic                in_fire;
  logic [SET_W-1:0]    in_set;
  logic [ADDR_W-1:0]   in_addr;
  logic                we;
  logic                load_out;
  row_t                rdata;
  row_t                row;
  row_t                row_mod;
  victim_t             victim;
  logic [NUM_WAYS+MASK_W-1:0] mask_ext;
  logic [NUM_WAYS-1:0] enable;
  logic [VWAY_W+WAY_W-1:0]    vway_ext;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_set  = s_axis_tdata[SET_LSB +: SET_W];
  assign in_addr = set_addr(in_set);

  // time memory
  lvs_time_ram #(
    .DEPTH  (NUM_SETS),
    .WIDTH  ($bits(row_t)),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (set_addr(set_q)),
    .wdata_i (row_mod),
    .re_i    (in_fire),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  // a row never written reads as all zero
  assign row = rvld_q ? rdata : '0;

  // row with the addressed way replaced
  always_comb begin
    row_mod = row;
    row_mod[way_slot(way_q)] = (cmd_q == CMD_TOUCH) ? fit_time(now_q) : '0;
  end

  // ways without a mask bit count as enabled
  assign mask_ext = {{NUM_WAYS{1'b0}}, mask_q};
  assign enable   = ~mask_ext[NUM_WAYS-1:0];

  lvs_victim_pick u_pick (
    .row_i    (row),
    .enable_i (enable),
    .set_ok_i (set_ok(set_q)),
    .victim_o (victim)
  );

  assign vway_ext = {{VWAY_W{1'b0}}, victim.way};

  // sequencer
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    we            = 1'b0;
    load_out      = 1'b0;
    out_valid_d   = out_valid_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_q)
          CMD_INVAL, CMD_TOUCH: begin
            we      = set_ok(set_q) && way_ok(way_q);
            state_d = ST_IDLE;
          end
          CMD_QUERY: begin
            if (!out_valid_q || m_axis_tready) begin
              load_out    = 1'b1;
              out_valid_d = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (we) begin
        valid_q[set_addr(set_q)] <= 1'b1;
      end
    end
  end

  // captured word and row valid flag
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= s_axis_tdata[CMD_LSB +: CMD_W];
      set_q  <= in_set;
      way_q  <= s_axis_tdata[WAY_LSB +: WAYF_W];
      now_q  <= s_axis_tdata[NOW_LSB +: NOW_W];
      mask_q <= s_axis_tdata[MASK_LSB +: MASK_W];
      rvld_q <= valid_q[in_addr];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_found_q <= victim.found;
      out_way_q   <= vway_ext[VWAY_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, out_way_q, out_found_q};

endmodule

// ===== hdl/lvs_time_ram.sv =====
// lvs_time_ram: generic single-write, single-read ram with registered read data
// holds one row of way time stamps per set; no dependencies

module lvs_time_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 128,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lvs_victim_pick.sv =====
// lvs_victim_pick: oldest enabled way of one set row, lowest way on equal times
// depends on lvs_pkg for the row and result types

module lvs_victim_pick (
  input  lvs_pkg::row_t                   row_i,
  input  logic [lvs_pkg::NUM_WAYS-1:0]    enable_i,
  input  logic                            set_ok_i,
  output lvs_pkg::victim_t                victim_o
);
  import lvs_pkg::*;

  logic [TIME_BITS-1:0] best_time;

  // walk the ways in order, strict compare keeps the lower way on ties
  always_comb begin
    victim_o  = '0;
    best_time = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (set_ok_i && enable_i[w] && (!victim_o.found || (row_i[w] < best_time))) begin
        victim_o.found = 1'b1;
        victim_o.way   = WAY_W'(w);
        best_time      = row_i[w];
      end
    end
  end

endmodule
